// ----- design/htn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htn_pkg
// Types, entity tables and slot layout for the HTML text normalizer.
// ----------------------------------------------------------------------------
package htn_pkg;

  typedef logic [7:0] char_t;
  typedef logic [2:0] ent_idx_t;

  localparam int ENT_DEPTH = 5;
  localparam int NUM_ENTS  = 6;
  localparam int ENT_MAXLEN = 6;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ENTITY = 2'd1;
  localparam logic [1:0] MODE_DIGITS = 2'd2;

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_AMP   = 8'h26;
  localparam char_t CH_HASH  = 8'h23;
  localparam char_t CH_SEMI  = 8'h3B;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_HIGH  = 8'h80;

  // Result slots of one job, in output order.
  localparam int SLOT_PRE   = 0;
  localparam int SLOT_AMP   = 1;
  localparam int SLOT_CHAR0 = 2;
  localparam int SLOT_X     = SLOT_CHAR0 + ENT_DEPTH;
  localparam int SLOT_AMP2  = SLOT_X + 1;
  localparam int SLOT_TERM  = SLOT_AMP2 + 1;
  localparam int NUM_SLOTS  = SLOT_TERM + 1;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  typedef struct packed {
    slot_mask_t                slots;
    char_t [ENT_DEPTH-1:0]     chars;
    char_t                     x;
  } job_t;

  localparam char_t ENT_TEXT [NUM_ENTS][ENT_MAXLEN] = '{
    '{"n", "b", "s", "p", ";", 8'h00},
    '{"a", "m", "p", ";", 8'h00, 8'h00},
    '{"l", "t", ";", 8'h00, 8'h00, 8'h00},
    '{"g", "t", ";", 8'h00, 8'h00, 8'h00},
    '{"r", "a", "q", "u", "o", ";"},
    '{"c", "o", "p", "y", ";", 8'h00}
  };

  localparam logic [2:0] ENT_LEN [NUM_ENTS] = '{3'd5, 3'd4, 3'd3, 3'd3, 3'd6, 3'd5};

  localparam char_t ENT_OUT [NUM_ENTS] = '{" ", "&", "<", ">", ">", "C"};

endpackage

// ----- design/htn_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htn_in_if
// Raw text channel: one byte and an end-of-text flag per item.
// ----------------------------------------------------------------------------
interface htn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

// ----- design/htn_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htn_out_if
// Normalized text channel: one character or terminator per item.
// ----------------------------------------------------------------------------
interface htn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output text_done, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input text_done, output ready);
endinterface

// ----- design/htn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htn_front
// Accepts raw bytes, tracks entity and whitespace state, and turns each
// byte into a job that lists the result slots it causes.
// ----------------------------------------------------------------------------
module htn_front (
  input  logic           clk,
  input  logic           rst,
  htn_in_if.sink         raw,
  output htn_pkg::job_t  job,
  output logic           job_push,
  input  logic           job_full
);
  import htn_pkg::*;

  logic [1:0]             mode;
  ent_idx_t               ent_k;
  char_t [ENT_DEPTH-1:0]  chars;
  logic [2:0]             cnt;
  logic                   in_ws;
  logic                   wrote;
  logic                   held;

  logic [1:0]             mode_next;
  ent_idx_t               ent_k_next;
  char_t [ENT_DEPTH-1:0]  chars_next;
  logic [2:0]             cnt_next;
  logic                   in_ws_next;
  logic                   wrote_next;
  logic                   held_next;

  logic                   accept;
  char_t                  b;
  logic [2:0]             n;
  logic                   do_flush;
  logic                   do_normal;
  logic                   emit_sp;
  logic                   emit_c;
  char_t                  c;
  logic                   pre;
  logic                   fl;
  logic [2:0]             fln;
  logic                   xv;
  logic                   amp2;
  logic                   term;
  logic                   found;
  ent_idx_t               found_k;

  assign raw.ready = !job_full;
  assign accept    = raw.valid && raw.ready;
  assign b         = raw.in_byte;
  assign n         = (cnt > 3'(ENT_DEPTH)) ? 3'(ENT_DEPTH) : cnt;

  always_comb begin
    found   = 1'b0;
    found_k = '0;
    for (int i = 0; i < NUM_ENTS; i++) begin
      if (!found && ENT_TEXT[i][0] == b) begin
        found   = 1'b1;
        found_k = ent_idx_t'(i);
      end
    end
  end

  always_comb begin
    mode_next  = mode;
    ent_k_next = ent_k;
    chars_next = chars;
    cnt_next   = cnt;
    in_ws_next = in_ws;
    wrote_next = wrote;
    held_next  = held;
    do_flush   = 1'b0;
    do_normal  = 1'b0;
    emit_sp    = 1'b0;
    emit_c     = 1'b0;
    c          = b;
    pre        = 1'b0;
    fl         = 1'b0;
    fln        = '0;
    xv         = 1'b0;
    amp2       = 1'b0;
    term       = 1'b0;

    case (mode)
      MODE_DIGITS: begin
        if (!(b inside {[CH_ZERO:CH_NINE]})) begin
          mode_next = MODE_NORMAL;
          if (b != CH_SEMI) begin
            do_normal = 1'b1;
          end
        end
      end
      MODE_ENTITY: begin
        if (n == 3'd0) begin
          if (b == CH_HASH) begin
            mode_next = MODE_DIGITS;
            emit_sp   = 1'b1;
          end else if (found) begin
            chars_next[0] = b;
            ent_k_next    = found_k;
            cnt_next      = 3'd1;
          end else begin
            do_flush  = 1'b1;
            do_normal = 1'b1;
          end
        end else if (n < ENT_LEN[ent_k] && ENT_TEXT[ent_k][n] == b) begin
          if ((n + 3'd1) == ENT_LEN[ent_k]) begin
            mode_next = MODE_NORMAL;
            cnt_next  = '0;
            if (ENT_OUT[ent_k] == CH_SPACE) begin
              emit_sp = 1'b1;
            end else begin
              emit_c = 1'b1;
              c      = ENT_OUT[ent_k];
            end
          end else if (n < 3'(ENT_DEPTH)) begin
            chars_next[n] = b;
            cnt_next      = n + 3'd1;
          end
        end else begin
          do_flush  = 1'b1;
          do_normal = 1'b1;
        end
      end
      default: begin
        do_normal = 1'b1;
      end
    endcase

    // A flush clears the held space, so later emits never push a second one.
    if (do_flush) begin
      if (held_next) pre = 1'b1;
      fl         = 1'b1;
      fln        = n;
      held_next  = 1'b0;
      wrote_next = 1'b1;
      mode_next  = MODE_NORMAL;
      cnt_next   = '0;
    end

    if (do_normal) begin
      if (b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB) begin
        if (!in_ws_next) begin
          if (wrote_next) emit_sp = 1'b1;
          in_ws_next = 1'b1;
        end
      end else begin
        in_ws_next = 1'b0;
        if (b == CH_AMP) begin
          mode_next = MODE_ENTITY;
          cnt_next  = '0;
        end else if (b < CH_HIGH) begin
          emit_c = 1'b1;
          c      = b;
        end
      end
    end

    if (emit_sp) begin
      if (held_next) pre = 1'b1;
      held_next  = 1'b1;
      wrote_next = 1'b1;
    end
    if (emit_c) begin
      if (held_next) pre = 1'b1;
      held_next  = 1'b0;
      wrote_next = 1'b1;
      xv         = 1'b1;
    end

    if (raw.text_end) begin
      if (mode_next == MODE_ENTITY) begin
        if (fl) begin
          amp2 = 1'b1;
        end else begin
          if (held_next) pre = 1'b1;
          fl  = 1'b1;
          fln = (cnt_next > 3'(ENT_DEPTH)) ? 3'(ENT_DEPTH) : cnt_next;
        end
      end
      term = 1'b1;
    end
  end

  always_comb begin
    job.slots = '0;
    job.slots[SLOT_PRE] = pre;
    job.slots[SLOT_AMP] = fl;
    for (int i = 0; i < ENT_DEPTH; i++) begin
      job.slots[SLOT_CHAR0 + i] = fl && (fln > 3'(i));
    end
    job.slots[SLOT_X]    = xv;
    job.slots[SLOT_AMP2] = amp2;
    job.slots[SLOT_TERM] = term;
    job.chars = chars_next;
    job.x     = c;
  end

  assign job_push = accept && (|job.slots);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_NORMAL;
      ent_k <= '0;
      cnt   <= '0;
      in_ws <= 1'b0;
      wrote <= 1'b0;
      held  <= 1'b0;
    end else if (accept) begin
      if (raw.text_end) begin
        mode  <= MODE_NORMAL;
        ent_k <= '0;
        cnt   <= '0;
        in_ws <= 1'b0;
        wrote <= 1'b0;
        held  <= 1'b0;
      end else begin
        mode  <= mode_next;
        ent_k <= ent_k_next;
        cnt   <= cnt_next;
        in_ws <= in_ws_next;
        wrote <= wrote_next;
        held  <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chars <= chars_next;
    end
  end

endmodule

// ----- design/htn_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htn_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module htn_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  htn_pkg::job_t  wr_data,
  input  logic           wr_en,
  output logic           full,
  output htn_pkg::job_t  rd_data,
  output logic           rd_valid,
  input  logic           rd_en
);
  import htn_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- design/htn_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htn_back
// Walks the slots of the job at the queue head, one result per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module htn_back (
  input  logic           clk,
  input  logic           rst,
  input  htn_pkg::job_t  job,
  input  logic           job_valid,
  output logic           job_pop,
  htn_out_if.source      clean
);
  import htn_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);

  slot_mask_t   rem;
  logic         started;
  slot_mask_t   cur;
  slot_mask_t   lowbit;
  slot_mask_t   after;
  logic [SW-1:0] sel;
  logic [2:0]   ci;
  logic         fire;
  char_t        d_byte;
  logic         d_valid;
  logic         d_done;

  assign cur    = started ? rem : job.slots;
  assign lowbit = cur & (~cur + slot_mask_t'(1));
  assign after  = cur & ~lowbit;
  assign fire   = job_valid && (!clean.valid || clean.ready);
  assign job_pop = fire && (after == '0);

  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur[i]) sel = SW'(i);
    end
  end

  assign ci = 3'(sel - SW'(SLOT_CHAR0));

  always_comb begin
    d_valid = 1'b1;
    d_done  = 1'b0;
    case (sel)
      SW'(SLOT_PRE):  d_byte = CH_SPACE;
      SW'(SLOT_AMP):  d_byte = CH_AMP;
      SW'(SLOT_X):    d_byte = job.x;
      SW'(SLOT_AMP2): d_byte = CH_AMP;
      SW'(SLOT_TERM): begin
        d_byte  = '0;
        d_valid = 1'b0;
        d_done  = 1'b1;
      end
      default:        d_byte = job.chars[ci];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      clean.valid <= 1'b0;
    end else begin
      if (fire) begin
        started <= (after != '0);
      end
      if (fire) begin
        clean.valid <= 1'b1;
      end else if (clean.ready) begin
        clean.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rem              <= after;
      clean.out_byte   <= d_byte;
      clean.byte_valid <= d_valid;
      clean.run_last   <= (after == '0);
      clean.text_done  <= d_done;
    end
  end

endmodule

// ----- design/html_text_normalizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_text_normalizer_core
// Streaming HTML text cleaner: whitespace collapse and entity decoding.
// ----------------------------------------------------------------------------
// Usage:
//   raw carries one text byte per item with text_end set on the last byte of
//   a text. clean carries the normalized characters; each raw item yields
//   zero to nine results, run_last marks the last result of an item and a
//   terminator result (byte_valid low, text_done high) closes every text.
//   The front part takes one raw item per cycle and writes a job into a
//   queue of QUEUE_DEPTH entries; the back part turns a job into one result
//   per cycle through a registered output stage.
//   An accepted item's job is registered in the queue, and then its first
//   result in the output register. Throughput is one raw item per cycle
//   while items yield at most one result each; an item with several results
//   holds the back part while they go out, and raw.ready drops only when the queue is full.
//   When clean is stalled the output register holds its item, the back part
//   waits and the queue keeps absorbing raw items until it fills.
//   Reset clears the scan state, the queue and the output valid.
// ----------------------------------------------------------------------------
module html_text_normalizer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  htn_in_if.sink     raw,
  htn_out_if.source  clean
);
  import htn_pkg::*;

  job_t  push_job;
  logic  push_en;
  logic  q_full;
  job_t  head_job;
  logic  head_valid;
  logic  head_pop;

  htn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .raw      (raw),
    .job      (push_job),
    .job_push (push_en),
    .job_full (q_full)
  );

  htn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (push_job),
    .wr_en    (push_en),
    .full     (q_full),
    .rd_data  (head_job),
    .rd_valid (head_valid),
    .rd_en    (head_pop)
  );

  htn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_valid (head_valid),
    .job_pop   (head_pop),
    .clean     (clean)
  );

endmodule

// ----- design/htn_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htn_checker
// Port-level checks of the normalizer output stream.
// ----------------------------------------------------------------------------
module htn_checker (
  input  logic       clk,
  input  logic       rst,
  htn_out_if.source  clean
);

  // A terminator always closes the item that caused it.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    clean.valid && clean.text_done |-> clean.run_last && !clean.byte_valid)
    else $error("text_done result is not a bare last result");

  // Only the terminator carries no character.
  a_bare_is_done: assert property (@(posedge clk) disable iff (rst)
    clean.valid && !clean.byte_valid |-> clean.text_done)
    else $error("bare result without text_done");

  // High bytes are dropped, so no emitted character is at or above 0x80.
  a_no_high_byte: assert property (@(posedge clk) disable iff (rst)
    clean.valid && clean.byte_valid |-> clean.out_byte < 8'h80)
    else $error("emitted character at or above 0x80");

  a_out_idle_after_reset: assert property (@(posedge clk)
    rst |=> !clean.valid)
    else $error("output valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    clean.valid && !clean.ready |=> clean.valid && $stable(clean.out_byte)
      && $stable(clean.run_last) && $stable(clean.text_done))
    else $error("stalled output item changed");

endmodule

bind html_text_normalizer_core htn_checker u_htn_checker (
  .clk   (clk),
  .rst   (rst),
  .clean (clean)
);

// ----- tb/htn_output_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htn_output_checker
// Watches the raw and clean channels of the HTML text normalizer. Every raw
// item accepted is run through a software copy of the scanner, and every
// clean item that comes out is compared with the oldest character expected.
// ----------------------------------------------------------------------------
module htn_output_checker (
  input  logic      clk,
  input  logic      rst,
  htn_in_if         raw,
  htn_out_if        clean,
  output int        fail_count,
  output int        pending,
  output int        raw_count,
  output int        char_count,
  output int        text_count
);
  import htn_pkg::*;

  localparam int MAX_PER_ITEM = 9;

  typedef enum logic [1:0] {SCAN_TEXT, SCAN_NAME, SCAN_NUMBER} scan_e;

  typedef struct packed {
    char_t ch;
    logic  valid;
    logic  last;
    logic  done;
  } clean_item_t;

  string ent_names [6] = '{"nbsp;", "amp;", "lt;", "gt;", "raquo;", "copy;"};
  char_t ent_result [6] = '{" ", "&", "<", ">", ">", "C"};

  clean_item_t expected_chars[$];
  clean_item_t step_chars[$];

  scan_e       scan_state;
  char_t       name_buf [ENT_DEPTH];
  int unsigned name_len;
  bit          in_ws;
  bit          wrote_any;
  bit          held_space;

  function automatic void clear_scan();
    scan_state = SCAN_TEXT;
    name_len   = 0;
    in_ws      = 0;
    wrote_any  = 0;
    held_space = 0;
  endfunction

  function automatic void put(char_t c, bit v);
    clean_item_t r;
    r = '{ch: c, valid: v, last: 1'b0, done: 1'b0};
    if (step_chars.size() < MAX_PER_ITEM) step_chars.push_back(r);
  endfunction

  function automatic void put_char(char_t c);
    if (held_space) begin
      put(" ", 1'b1);
      held_space = 0;
    end
    put(c, 1'b1);
    wrote_any = 1;
  endfunction

  // A space is always held back one character so a trailing one can vanish.
  function automatic void put_space();
    if (held_space) put(" ", 1'b1);
    held_space = 1;
    wrote_any  = 1;
  endfunction

  function automatic int ent_lookup(char_t c);
    for (int i = 0; i < 6; i++) begin
      if (char_t'(ent_names[i][0]) == c) return i;
    end
    return -1;
  endfunction

  function automatic void flush_name();
    put_char("&");
    for (int unsigned i = 0; i < name_len && i < ENT_DEPTH; i++) put_char(name_buf[i]);
    scan_state = SCAN_TEXT;
    name_len   = 0;
  endfunction

  function automatic void plain_byte(char_t b);
    if (b == " " || b == 8'h0A || b == 8'h0D || b == 8'h09) begin
      if (!in_ws) begin
        if (wrote_any) put_space();
        in_ws = 1;
      end
      return;
    end
    in_ws = 0;
    if (b == "&") begin
      scan_state = SCAN_NAME;
      name_len   = 0;
    end else if (b < 8'h80) begin
      put_char(b);
    end
  endfunction

  function automatic void decode_byte(char_t b);
    int          k;
    int unsigned n;
    case (scan_state)
      SCAN_NUMBER: begin
        if (b >= "0" && b <= "9") return;
        scan_state = SCAN_TEXT;
        if (b != ";") plain_byte(b);
      end
      SCAN_NAME: begin
        n = name_len;
        if (n == 0) begin
          if (b == "#") begin
            scan_state = SCAN_NUMBER;
            put_space();
            return;
          end
          if (ent_lookup(b) >= 0) begin
            name_buf[0] = b;
            name_len    = 1;
            return;
          end
        end else begin
          k = ent_lookup(name_buf[0]);
          if (k >= 0 && n < ent_names[k].len() && char_t'(ent_names[k][n]) == b) begin
            if (n + 1 == ent_names[k].len()) begin
              scan_state = SCAN_TEXT;
              name_len   = 0;
              if (ent_result[k] == " ") put_space();
              else put_char(ent_result[k]);
            end else if (n < ENT_DEPTH) begin
              name_buf[n] = b;
              name_len    = n + 1;
            end
            return;
          end
        end
        // The prefix stopped matching: it goes out as typed, then the byte.
        flush_name();
        plain_byte(b);
      end
      default: plain_byte(b);
    endcase
  endfunction

  function automatic void predict_item(char_t b, bit text_end);
    step_chars.delete();
    decode_byte(b);
    if (text_end) begin
      if (scan_state == SCAN_NAME) flush_name();
      put(8'h00, 1'b0);
      step_chars[step_chars.size()-1].done = 1'b1;
      clear_scan();
    end
    if (step_chars.size() > 0) step_chars[step_chars.size()-1].last = 1'b1;
    foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
  endfunction

  always @(posedge clk) begin
    clean_item_t got;
    clean_item_t want;
    if (rst) begin
      clear_scan();
      expected_chars.delete();
      fail_count = 0;
      raw_count  = 0;
      char_count = 0;
      text_count = 0;
    end else begin
      if (raw.valid && raw.ready) begin
        predict_item(raw.in_byte, raw.text_end);
        raw_count++;
      end
      if (clean.valid && clean.ready) begin
        got = '{ch: clean.out_byte, valid: clean.byte_valid, last: clean.run_last,
                done: clean.text_done};
        char_count++;
        if (got.done) text_count++;
        if (expected_chars.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected clean item: expected none, %s",
                   $time, $sformatf("got ch=%h valid=%b last=%b done=%b",
                                    got.ch, got.valid, got.last, got.done));
        end else begin
          want = expected_chars.pop_front();
          if (got.ch != want.ch || got.valid != want.valid || got.last != want.last ||
              got.done != want.done) begin
            fail_count++;
            $display("%0t: clean item mismatch: expected ch=%h valid=%b last=%b done=%b,",
                     $time, want.ch, want.valid, want.last, want.done,
                     " got ch=%h valid=%b last=%b done=%b",
                     got.ch, got.valid, got.last, got.done);
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the HTML text normalizer core.
// Sends a few hand-written texts that hit the corner cases, then random texts
// built from entities, broken prefixes, numeric references, whitespace and
// noise bytes, with random gaps on the raw side and stalls on the clean side.
// ----------------------------------------------------------------------------
module tb;
  import htn_pkg::*;

  localparam int RANDOM_ITEMS = 130;
  localparam int CALM_ITEMS   = 25;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct {
    char_t b;
    bit    last;
  } raw_item_t;

  logic clk;
  logic rst;

  htn_in_if  raw_ch ();
  htn_out_if clean_ch ();

  int fail_count;
  int pending;
  int raw_count;
  int char_count;
  int text_count;

  raw_item_t text_bytes[$];
  bit        calm;
  int        quiet;
  int        stall_left;

  string ent_names [6] = '{"nbsp;", "amp;", "lt;", "gt;", "raquo;", "copy;"};
  char_t ws_chars [4]  = '{" ", 8'h0A, 8'h0D, 8'h09};

  html_text_normalizer_core uut (
    .clk   (clk),
    .rst   (rst),
    .raw   (raw_ch),
    .clean (clean_ch)
  );

  htn_output_checker chk (
    .clk        (clk),
    .rst        (rst),
    .raw        (raw_ch),
    .clean      (clean_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .raw_count  (raw_count),
    .char_count (char_count),
    .text_count (text_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void add_byte(char_t b);
    raw_item_t it;
    it = '{b: b, last: 1'b0};
    text_bytes.push_back(it);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(char_t'(s[i]));
  endfunction

  function automatic void end_text();
    text_bytes[text_bytes.size()-1].last = 1'b1;
  endfunction

  // One random text: mostly well-formed markup fragments, some noise.
  function automatic void add_random_text();
    int    tokens;
    int    k;
    int    n;
    string s;
    tokens = $urandom_range(1, 10);
    for (int t = 0; t < tokens; t++) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          add_byte("&");
          add_str(ent_names[$urandom_range(0, 5)]);
        end
        3: begin
          k = $urandom_range(0, 5);
          s = ent_names[k];
          add_byte("&");
          add_str(s.substr(0, $urandom_range(0, s.len() - 2)));
        end
        4: begin
          add_str("&#");
          n = $urandom_range(0, 3);
          repeat (n) add_byte(char_t'($urandom_range(8'h30, 8'h39)));
          if ($urandom_range(0, 1) == 1) add_byte(";");
        end
        5, 6: begin
          n = $urandom_range(1, 3);
          repeat (n) add_byte(ws_chars[$urandom_range(0, 3)]);
        end
        7, 8: add_byte(char_t'($urandom_range(8'h21, 8'h7E)));
        9: add_byte(char_t'($urandom_range(0, 255)));
        10: add_byte(char_t'($urandom_range(8'h80, 8'hFF)));
        default: begin
          add_byte("&");
          if ($urandom_range(0, 1) == 1) add_byte(char_t'($urandom_range(0, 255)));
        end
      endcase
    end
    end_text();
  endfunction

  // Clean side: random stall bursts, no new burst once the run has gone calm.
  initial begin
    clean_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        clean_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        clean_ch.ready <= 1'b0;
      end else begin
        clean_ch.ready <= 1'b1;
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((raw_ch.valid && raw_ch.ready) || (clean_ch.valid && clean_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog expired, no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int directed_items;
    rst = 1'b1;
    calm = 1'b0;
    raw_ch.valid = 1'b0;
    raw_ch.in_byte = 8'h00;
    raw_ch.text_end = 1'b0;

    // Leading whitespace, a high byte, a zero byte and a trailing space.
    add_str("\t&lt;");
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(" ");
    end_text();
    // Longest prefix broken after a held space: the busiest item.
    add_str("x &raquoz");
    end_text();
    // Numeric reference, then a bare ampersand left open at the end.
    add_str("&#12;&");
    end_text();
    // A text that produces nothing but its terminator.
    add_byte(8'h80);
    end_text();
    directed_items = text_bytes.size();
    while (text_bytes.size() < directed_items + RANDOM_ITEMS) add_random_text();

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (text_bytes[i]) begin
      if (i >= text_bytes.size() - CALM_ITEMS) calm = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) begin
        raw_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      raw_ch.valid    <= 1'b1;
      raw_ch.in_byte  <= text_bytes[i].b;
      raw_ch.text_end <= text_bytes[i].last;
      do @(posedge clk); while (!raw_ch.ready);
      @(negedge clk);
    end
    raw_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d raw items in %0d texts (%0d directed items).",
             raw_count, text_count, directed_items);
    $display("Checked %0d clean items, %0d failures.", char_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
